FILE: rtl/lsws_pkg.sv
`timescale 1ns / 1ps

package lsws_pkg;

    localparam int WAYS         = 4;
    localparam int TAG_BITS     = 20;
    localparam int WAY_IDX_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAY_OUT_BITS = 2;

    typedef logic [TAG_BITS-1:0]     tag_t;
    typedef logic [WAY_IDX_BITS-1:0] way_idx_t;
    typedef logic [WAYS-1:0]         way_mask_t;

    // Outcome of one lookup in the set.
    typedef struct packed {
        logic     hit;
        logic     ev_valid;
        way_idx_t way;
    } decision_t;

endpackage

FILE: rtl/lru_set_way_select_core.sv
`timescale 1ns / 1ps
// Channel | direction | handshake           | payload
// --------+-----------+---------------------+---------------------------------------------
// in      | input     | in_valid / in_ready | access_tag[19:0]
// out     | output    | out_valid/out_ready | hit, way_used[1:0], evicted_valid, evicted_tag
//
// One access beat per cycle sustained while the output is not stalled (out_ready high).
// The beat lands in an input register, the set lookup and LRU update run in one
// combinational pass, and the result register loads as the set state updates.
// Reset empties the set and restores LRU order 0..WAYS-1; tags are unreset.
// A stalled output holds its beat; one more beat waits in the input register.

module lru_set_way_select_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [19:0]           access_tag,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  hit,
    output logic [1:0]            way_used,
    output logic                  evicted_valid,
    output logic [19:0]           evicted_tag
);
    import lsws_pkg::*;

    // Input register
    logic      s1_valid_reg;
    tag_t      s1_tag_reg;

    // Set state
    tag_t      tags_reg [WAYS];
    way_mask_t valid_reg;

    // Result register
    logic      out_valid_reg;
    logic      hit_reg;
    logic [WAY_OUT_BITS-1:0] way_reg;
    logic      ev_valid_reg;
    tag_t      ev_tag_reg;

    logic      advance;
    way_idx_t  lru_way;
    decision_t decision;
    logic [WAY_IDX_BITS+WAY_OUT_BITS-1:0] way_wide;

    // Move the staged beat forward whenever the result register is free or draining.
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    lsws_lookup u_lookup (
        .tag       (s1_tag_reg),
        .way_tags  (tags_reg),
        .way_valid (valid_reg),
        .lru_way   (lru_way),
        .decision  (decision)
    );

    // Promote the used way on every completed access, hit or fill.
    lsws_recency u_recency (
        .clk       (clk),
        .rst_n     (rst_n),
        .touch     (advance),
        .touch_way (decision.way),
        .lru_way   (lru_way)
    );

    assign way_wide = {{WAY_OUT_BITS{1'b0}}, decision.way};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                if (!decision.hit)
                    valid_reg[decision.way] <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_tag_reg <= TAG_BITS'(access_tag);
        if (advance)
        begin
            // Fill the chosen way on a miss.
            if (!decision.hit)
                tags_reg[decision.way] <= s1_tag_reg;
            hit_reg      <= decision.hit;
            way_reg      <= way_wide[WAY_OUT_BITS-1:0];
            ev_valid_reg <= decision.ev_valid;
            ev_tag_reg   <= decision.ev_valid ? tags_reg[decision.way] : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign way_used      = way_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_tag   = 20'(ev_tag_reg);

`ifndef SYNTH
    // A hit never evicts.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !evicted_valid)
        else $error("hit result reports an eviction");

    // Ways only fill; nothing but reset empties them.
    a_valid_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_reg & $past(valid_reg)) == $past(valid_reg)))
        else $error("a way lost its valid bit");

    // An eviction happens only with a full set, and the set stays full.
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted_valid |-> (&valid_reg))
        else $error("eviction reported while the set has an empty way");
`endif

endmodule

FILE: rtl/lsws_lookup.sv
`timescale 1ns / 1ps

module lsws_lookup (
    input  lsws_pkg::tag_t      tag,
    input  lsws_pkg::tag_t      way_tags  [lsws_pkg::WAYS],
    input  lsws_pkg::way_mask_t way_valid,
    input  lsws_pkg::way_idx_t  lru_way,
    output lsws_pkg::decision_t decision
);
    import lsws_pkg::*;

    always_comb
    begin
        logic     hit_found;
        logic     empty_found;
        way_idx_t hit_way;
        way_idx_t empty_way;

        hit_found   = 1'b0;
        empty_found = 1'b0;
        hit_way     = '0;
        empty_way   = '0;
        // Scan from the top down so the lowest-numbered way wins.
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (way_valid[i] && (way_tags[i] == tag))
            begin
                hit_found = 1'b1;
                hit_way   = WAY_IDX_BITS'(i);
            end
            if (!way_valid[i])
            begin
                empty_found = 1'b1;
                empty_way   = WAY_IDX_BITS'(i);
            end
        end

        decision.hit      = hit_found;
        decision.ev_valid = 1'b0;
        priority if (hit_found)
            decision.way = hit_way;
        else if (empty_found)
            decision.way = empty_way;
        else
        begin
            decision.way      = lru_way;
            decision.ev_valid = 1'b1;
        end
    end

endmodule

FILE: rtl/lsws_recency.sv
`timescale 1ns / 1ps

module lsws_recency (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               touch,
    input  lsws_pkg::way_idx_t touch_way,
    output lsws_pkg::way_idx_t lru_way
);
    import lsws_pkg::*;

    // Position 0 is most recently used, position WAYS-1 least.
    way_idx_t order_reg  [WAYS];
    way_idx_t order_next [WAYS];

    always_comb
    begin
        way_idx_t pos;

        pos = WAY_IDX_BITS'(WAYS - 1);
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (order_reg[i] == touch_way)
                pos = WAY_IDX_BITS'(i);
        end
        // Shift everything above the touched position down by one.
        order_next[0] = touch_way;
        for (int i = 1; i < WAYS; i++)
        begin
            if (WAY_IDX_BITS'(i) <= pos)
                order_next[i] = order_reg[i-1];
            else
                order_next[i] = order_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WAYS; i++)
                order_reg[i] <= WAY_IDX_BITS'(i);
        end
        else if (touch)
        begin
            order_reg <= order_next;
        end
    end

    assign lru_way = order_reg[WAYS-1];

endmodule
